// ===== design/rsn_pkg.sv =====
package rsn_pkg;

   // default table depth
   localparam int SLOTS_DEFAULT = 16;

   // field widths
   localparam int TAG_W   = 32;
   localparam int POS_W   = 24;
   localparam int DIR_W   = 16;
   localparam int RANGE_W = 24;
   localparam int RAD_W   = 16;

   // radius after reset, 1.0 in Q8.8
   localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd256;

   // request mode codes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_CAST  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic start;   // latch cast word, reset best
      logic wr_en;   // write table slot
      logic clr_en;  // clear table slot
      logic issue;   // read one slot into the pipe
      logic finish;  // load result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pipe_busy;
      logic rsp_free;
   } status_type;

   // one table entry
   typedef struct packed {
      logic [TAG_W-1:0]        tag;
      logic                    team;
      logic                    alive;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } entry_type;

endpackage

// ===== design/rsn_ifs.sv =====
interface rsn_req_if;
   logic                  valid;
   logic                  ready;
   logic [1:0]            mode;
   logic [3:0]            slot;
   logic [31:0]           entity_tag;
   logic                  team_bit;
   logic                  alive_bit;
   logic signed [23:0]    pos_x;
   logic signed [23:0]    pos_y;
   logic signed [23:0]    pos_z;
   logic signed [15:0]    dir_x;
   logic signed [15:0]    dir_y;
   logic signed [15:0]    dir_z;
   logic [23:0]           max_range;

   modport source (output valid, mode, slot, entity_tag, team_bit, alive_bit,
                   pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, max_range,
                   input ready);
   modport sink (input valid, mode, slot, entity_tag, team_bit, alive_bit,
                 pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, max_range,
                 output ready);
endinterface

interface rsn_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit_found;
   logic [31:0] hit_tag;
   logic [23:0] hit_distance;

   modport source (output valid, hit_found, hit_tag, hit_distance, input ready);
   modport sink (input valid, hit_found, hit_tag, hit_distance, output ready);
endinterface

interface rsn_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] hit_radius;

   modport source (output valid, hit_radius, input ready);
   modport sink (input valid, hit_radius, output ready);
endinterface

// ===== design/rsn_ctrl.sv =====
module rsn_ctrl #(
   parameter int TARGET_SLOTS = rsn_pkg::SLOTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [1:0]                          req_mode,
   output logic                                req_ready,
   input  rsn_pkg::status_type                 status,
   output rsn_pkg::cmd_type                    cmd,
   output logic [$clog2(TARGET_SLOTS)-1:0]     issue_idx
);
   import rsn_pkg::*;

   localparam int IDX_W = $clog2(TARGET_SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   assign issue_idx = idx_ff;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_mode)
                  MODE_WRITE: cmd.wr_en = 1'b1;
                  MODE_CLEAR: cmd.clr_en = 1'b1;
                  MODE_CAST: begin
                     cmd.start = 1'b1;
                     idx_in    = '0;
                     state_in  = ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            cmd.issue = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(TARGET_SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== design/rsn_datapath.sv =====
module rsn_datapath #(
   parameter int TARGET_SLOTS = rsn_pkg::SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   rsn_req_if.sink                          req,
   rsn_rsp_if.source                        rsp,
   rsn_csr_if.sink                          csr,
   input  rsn_pkg::cmd_type                 cmd,
   input  logic [$clog2(TARGET_SLOTS)-1:0]  issue_idx,
   output rsn_pkg::status_type              status
);
   import rsn_pkg::*;

   localparam int IDX_W = $clog2(TARGET_SLOTS);

   // config: radius and its square
   logic [RAD_W-1:0]   radius_ff;
   logic [2*RAD_W-1:0] r2_ff;
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr.valid) begin
         radius_ff <= csr.hit_radius;
      end
      r2_ff <= radius_ff * radius_ff;
   end

   // target table
   entry_type                entry_mem [TARGET_SLOTS];
   logic [TARGET_SLOTS-1:0]  valid_ff;
   logic [8:0]               slot_wide;
   logic                     slot_ok;
   logic [IDX_W-1:0]         wr_addr;
   entry_type                wr_entry;

   assign slot_wide = 9'(req.slot);
   assign slot_ok   = slot_wide < 9'(TARGET_SLOTS);
   assign wr_addr   = slot_wide[IDX_W-1:0];
   assign wr_entry  = '{tag: req.entity_tag, team: req.team_bit, alive: req.alive_bit,
                        x: req.pos_x, y: req.pos_y, z: req.pos_z};

   always_ff @(posedge clock) begin
      if (cmd.wr_en && slot_ok) begin
         entry_mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (slot_ok && (cmd.wr_en || cmd.clr_en)) begin
         valid_ff[wr_addr] <= cmd.wr_en;
      end
   end

   // cast word latched at start
   logic signed [POS_W-1:0] org_x_ff, org_y_ff, org_z_ff;
   logic signed [DIR_W-1:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [TAG_W-1:0]        shooter_ff;
   logic                    sh_team_ff;
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         org_x_ff   <= req.pos_x;
         org_y_ff   <= req.pos_y;
         org_z_ff   <= req.pos_z;
         dir_x_ff   <= req.dir_x;
         dir_y_ff   <= req.dir_y;
         dir_z_ff   <= req.dir_z;
         shooter_ff <= req.entity_tag;
         sh_team_ff <= req.team_bit;
      end
   end

   // pipe valids: a read, b diff, c products, d dot, e dir*p, f miss, g squares
   logic [6:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[5:0], cmd.issue};
      end
   end
   assign status.pipe_busy = |vld_ff;

   // stage a: registered table read
   entry_type a_ent_ff;
   logic      a_val_ff;
   always_ff @(posedge clock) begin
      a_ent_ff <= entry_mem[issue_idx];
      a_val_ff <= valid_ff[issue_idx];
   end

   // stage b: eligibility and centre minus origin
   logic signed [POS_W:0] b_dx_ff, b_dy_ff, b_dz_ff;
   logic                  b_ok_ff;
   logic [TAG_W-1:0]      b_tag_ff;
   always_ff @(posedge clock) begin
      b_dx_ff  <= (POS_W+1)'(a_ent_ff.x) - (POS_W+1)'(org_x_ff);
      b_dy_ff  <= (POS_W+1)'(a_ent_ff.y) - (POS_W+1)'(org_y_ff);
      b_dz_ff  <= (POS_W+1)'(a_ent_ff.z) - (POS_W+1)'(org_z_ff);
      b_ok_ff  <= a_val_ff && a_ent_ff.alive && (a_ent_ff.tag != shooter_ff)
                  && (a_ent_ff.team != sh_team_ff);
      b_tag_ff <= a_ent_ff.tag;
   end

   // stage c: per-axis products of the dot product
   logic signed [40:0]    c_px_ff, c_py_ff, c_pz_ff;
   logic signed [POS_W:0] c_dx_ff, c_dy_ff, c_dz_ff;
   logic                  c_ok_ff;
   logic [TAG_W-1:0]      c_tag_ff;
   always_ff @(posedge clock) begin
      c_px_ff  <= b_dx_ff * dir_x_ff;
      c_py_ff  <= b_dy_ff * dir_y_ff;
      c_pz_ff  <= b_dz_ff * dir_z_ff;
      c_dx_ff  <= b_dx_ff;
      c_dy_ff  <= b_dy_ff;
      c_dz_ff  <= b_dz_ff;
      c_ok_ff  <= b_ok_ff;
      c_tag_ff <= b_tag_ff;
   end

   // stage d: projection, rejected if negative or past any 24-bit range
   logic signed [42:0]    dot_s;
   logic signed [POS_W:0] d_dx_ff, d_dy_ff, d_dz_ff;
   logic [RANGE_W-1:0]    d_p_ff;
   logic                  d_ok_ff;
   logic [TAG_W-1:0]      d_tag_ff;
   assign dot_s = 43'(c_px_ff) + 43'(c_py_ff) + 43'(c_pz_ff);
   always_ff @(posedge clock) begin
      d_p_ff   <= dot_s[37:14];
      d_ok_ff  <= c_ok_ff && !dot_s[42] && (dot_s[41:38] == 4'd0);
      d_dx_ff  <= c_dx_ff;
      d_dy_ff  <= c_dy_ff;
      d_dz_ff  <= c_dz_ff;
      d_tag_ff <= c_tag_ff;
   end

   // stage e: direction times projection
   logic signed [RANGE_W:0] p_signed;
   logic signed [40:0]      e_qx_ff, e_qy_ff, e_qz_ff;
   logic signed [POS_W:0]   e_dx_ff, e_dy_ff, e_dz_ff;
   logic [RANGE_W-1:0]      e_p_ff;
   logic                    e_ok_ff;
   logic [TAG_W-1:0]        e_tag_ff;
   assign p_signed = {1'b0, d_p_ff};
   always_ff @(posedge clock) begin
      e_qx_ff  <= dir_x_ff * p_signed;
      e_qy_ff  <= dir_y_ff * p_signed;
      e_qz_ff  <= dir_z_ff * p_signed;
      e_dx_ff  <= d_dx_ff;
      e_dy_ff  <= d_dy_ff;
      e_dz_ff  <= d_dz_ff;
      e_p_ff   <= d_p_ff;
      e_ok_ff  <= d_ok_ff;
      e_tag_ff <= d_tag_ff;
   end

   // stage f: miss vector rounded to Q.8, ties up
   logic signed [41:0]  t_x, t_y, t_z;
   logic signed [27:0]  f_mx_ff, f_my_ff, f_mz_ff;
   logic [RANGE_W-1:0]  f_p_ff;
   logic                f_ok_ff;
   logic [TAG_W-1:0]    f_tag_ff;
   assign t_x = 42'(e_qx_ff) - (42'(e_dx_ff) <<< 14) + 42'sd8192;
   assign t_y = 42'(e_qy_ff) - (42'(e_dy_ff) <<< 14) + 42'sd8192;
   assign t_z = 42'(e_qz_ff) - (42'(e_dz_ff) <<< 14) + 42'sd8192;
   always_ff @(posedge clock) begin
      f_mx_ff  <= t_x[41:14];
      f_my_ff  <= t_y[41:14];
      f_mz_ff  <= t_z[41:14];
      f_p_ff   <= e_p_ff;
      f_ok_ff  <= e_ok_ff;
      f_tag_ff <= e_tag_ff;
   end

   // stage g: squares
   logic signed [55:0]  g_sx_ff, g_sy_ff, g_sz_ff;
   logic [RANGE_W-1:0]  g_p_ff;
   logic                g_ok_ff;
   logic [TAG_W-1:0]    g_tag_ff;
   always_ff @(posedge clock) begin
      g_sx_ff  <= f_mx_ff * f_mx_ff;
      g_sy_ff  <= f_my_ff * f_my_ff;
      g_sz_ff  <= f_mz_ff * f_mz_ff;
      g_p_ff   <= f_p_ff;
      g_ok_ff  <= f_ok_ff;
      g_tag_ff <= f_tag_ff;
   end

   // stage h: radius test against running best
   logic [57:0]        miss_sum;
   logic               take;
   logic               found_ff;
   logic [TAG_W-1:0]   best_tag_ff;
   logic [RANGE_W-1:0] best_ff;
   assign miss_sum = 58'(unsigned'(g_sx_ff)) + 58'(unsigned'(g_sy_ff))
                   + 58'(unsigned'(g_sz_ff));
   assign take = vld_ff[6] && g_ok_ff && (g_p_ff <= best_ff)
               && (miss_sum <= 58'(r2_ff));
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         found_ff    <= 1'b0;
         best_tag_ff <= '0;
         best_ff     <= req.max_range;
      end else if (take) begin
         found_ff    <= 1'b1;
         best_tag_ff <= g_tag_ff;
         best_ff     <= g_p_ff;
      end
   end

   // result register
   logic               rsp_vld_ff;
   logic               rsp_found_ff;
   logic [TAG_W-1:0]   rsp_tag_ff;
   logic [RANGE_W-1:0] rsp_dist_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_found_ff <= found_ff;
         rsp_tag_ff   <= best_tag_ff;
         rsp_dist_ff  <= best_ff;
      end
   end
   assign rsp.valid        = rsp_vld_ff;
   assign rsp.hit_found    = rsp_found_ff;
   assign rsp.hit_tag      = rsp_tag_ff;
   assign rsp.hit_distance = rsp_dist_ff;
   assign status.rsp_free  = !rsp_vld_ff || rsp.ready;

endmodule

// ===== design/ray_sphere_nearest_hit.sv =====
// Channel | Dir | Word
// req     | in  | mode, slot, entity_tag, team_bit, alive_bit, pos, dir, max_range
// rsp     | out | hit_found, hit_tag, hit_distance (one word per cast)
// csr     | in  | hit_radius, always ready
//
// A cast issues one table read per slot through an eight-stage compare
// pipe, then the pipe drains and the result register loads. The table has
// one read port. The result register holds a word until taken; a finished
// cast waits for it. Reset is synchronous: table valid bits, pipe and result
// are cleared.
module ray_sphere_nearest_hit #(
   parameter int TARGET_SLOTS = rsn_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rsn_req_if.sink     req,
   rsn_rsp_if.source   rsp,
   rsn_csr_if.sink     csr
);
   import rsn_pkg::*;

   cmd_type                         cmd;
   status_type                      status;
   logic [$clog2(TARGET_SLOTS)-1:0] issue_idx;

   rsn_ctrl #(.TARGET_SLOTS(TARGET_SLOTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.mode),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd),
      .issue_idx (issue_idx)
   );

   rsn_datapath #(.TARGET_SLOTS(TARGET_SLOTS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr       (csr),
      .cmd       (cmd),
      .issue_idx (issue_idx),
      .status    (status)
   );

   // no new word while slots are still in the pipe
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !status.pipe_busy)
      else $error("request taken while pipe busy");

   // result loads only after the pipe has drained
   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!status.pipe_busy && !cmd.issue))
      else $error("result loaded before drain");

   // a loaded result is shown next cycle
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp.valid)
      else $error("result not presented");

endmodule
